[rtl/core/cwp_pkg.sv]
// Shared constants and types for the Catmull-Rom waypoint path unit.
package cwp_pkg;

  localparam int MAX_POINTS = 16;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 32;
  localparam int PT_W       = 3 * COORD_W;
  localparam int T_W        = 16;
  localparam int SPEED_W    = 16;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = ACC_W + T_W + 1;
  localparam int INC_SH     = 8;
  localparam int INC_W      = SPEED_W + T_W - INC_SH;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(128);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [ACC_W-1:0] ACC_POS_MAX =
    {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_MIN =
    {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  // Control of the shared multiply / shift / add unit
  typedef struct packed {
    logic             mul_en;
    logic [ACC_W-1:0] mul_a;
    logic [T_W:0]     mul_b;
    logic [ACC_W-1:0] addend;
  } cwp_mac_ctrl_t;

endpackage

[rtl/core/cwp_if.sv]
// Valid/ready channel interfaces for waypoint commands and path positions.
interface cwp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [cwp_pkg::COORD_W-1:0]  point_x;
  logic signed [cwp_pkg::COORD_W-1:0]  point_y;
  logic signed [cwp_pkg::COORD_W-1:0]  point_z;
  logic        [cwp_pkg::T_W-1:0]      frame_time;

  modport source (output valid, opcode, point_x, point_y, point_z, frame_time,
                  input ready);
  modport sink (input valid, opcode, point_x, point_y, point_z, frame_time,
                output ready);
endinterface

interface cwp_pos_if;
  logic                                valid;
  logic                                ready;
  logic signed [cwp_pkg::COORD_W-1:0]  pos_x;
  logic signed [cwp_pkg::COORD_W-1:0]  pos_y;
  logic signed [cwp_pkg::COORD_W-1:0]  pos_z;
  logic                                clipped;

  modport source (output valid, pos_x, pos_y, pos_z, clipped, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, clipped, output ready);
endinterface

[rtl/core/cwp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cwp_mac.sv]
// Shared multiply unit: registered product, then floor shift and add.
module cwp_mac (
  input  logic                         clk_i,
  input  cwp_pkg::cwp_mac_ctrl_t       ctrl_i,
  output logic [cwp_pkg::PROD_W-1:0]   prod_o,
  output logic [cwp_pkg::ACC_W-1:0]    sum_o
);

  logic signed [cwp_pkg::PROD_W-1:0] prod_d;
  logic signed [cwp_pkg::PROD_W-1:0] prod_q;
  logic signed [cwp_pkg::PROD_W-1:0] prod_shr;

  assign prod_d = $signed(ctrl_i.mul_a) * $signed(ctrl_i.mul_b);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift gives the floor of the product by the Q0.16 factor
  assign prod_shr = prod_q >>> cwp_pkg::T_W;
  assign sum_o    = prod_shr[cwp_pkg::ACC_W-1:0] + ctrl_i.addend;
  assign prod_o   = prod_q;

endmodule

[rtl/core/catmull_rom_waypoint_path_unit.sv]
// Catmull-Rom closed-loop waypoint path unit: ring of waypoints, cubic evaluation.
// Append: taken in the idle state, no result; the unit stays ready.
// Tick: from transfer to result valid (4 waypoint reads, fraction update,
//   nine Horner steps on one shared 40x17 multiplier, wait for a free output), then ready.
// Reset (async, active low): empty ring, index and fraction zero, speed 0.5,
//   output empty; the waypoint RAM is not cleared.
module catmull_rom_waypoint_path_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cwp_pkg::SPEED_W-1:0]   cfg_wdata_i,
  cwp_cmd_if.sink                       cmd_if,
  cwp_pos_if.source                     pos_if
);

  localparam int AW     = cwp_pkg::AW;
  localparam int CW     = cwp_pkg::CW;
  localparam int ACC_W  = cwp_pkg::ACC_W;
  localparam int CRD_W  = cwp_pkg::COORD_W;
  localparam int T_W    = cwp_pkg::T_W;
  localparam int INC_W  = cwp_pkg::INC_W;
  localparam int SUM_W  = INC_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_INC  = 4'd3;
  localparam logic [3:0] S_INC2 = 4'd4;
  localparam logic [3:0] S_COEF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                  state_q;
  logic [cwp_pkg::SPEED_W-1:0] speed_q;
  logic [CW-1:0]               count_q;
  logic [AW-1:0]               seg_q;
  logic [T_W-1:0]              frac_q;

  logic [AW-1:0]               idx_q [4];
  logic [cwp_pkg::PT_W-1:0]    pt_q [4];
  logic [1:0]                  rd_slot_q;
  logic                        cap_q;
  logic [1:0]                  cap_slot_q;
  logic [T_W-1:0]              ft_q;
  logic [T_W-1:0]              nfrac_q;
  logic                        wrap_q;
  logic [1:0]                  k_q;
  logic [1:0]                  step_q;
  logic [ACC_W-1:0]            acc_q;
  logic [ACC_W-1:0]            coef_a_q;
  logic [ACC_W-1:0]            coef_b_q;
  logic [ACC_W-1:0]            coef_c_q;
  logic [CRD_W-1:0]            pos_q [3];
  logic                        clip_q;

  logic                        out_valid_q;
  logic [CRD_W-1:0]            out_x_q;
  logic [CRD_W-1:0]            out_y_q;
  logic [CRD_W-1:0]            out_z_q;
  logic                        out_clip_q;

  logic                        cmd_xfer;
  logic                        full;
  logic                        ram_we;
  logic                        ram_re;
  logic [cwp_pkg::PT_W-1:0]    ram_rdata;
  logic [AW-1:0]               i0, i2, i3;
  logic [AW-1:0]               last_idx;

  cwp_pkg::cwp_mac_ctrl_t      mac_ctrl;
  logic [cwp_pkg::PROD_W-1:0]  mac_prod;
  logic [ACC_W-1:0]            mac_sum;

  logic [ACC_W-1:0]            p0, p1, p2, p3;
  logic [ACC_W-1:0]            coef_a, coef_b, coef_c, coef_d;
  logic [INC_W-1:0]            inc;
  logic [SUM_W-1:0]            frac_sum;
  logic signed [ACC_W-1:0]     half_acc;
  logic                        sat_hi, sat_lo;
  logic [CRD_W-1:0]            sat_val;
  logic                        out_free;

  assign cmd_xfer      = cmd_if.valid && cmd_if.ready;
  assign cmd_if.ready  = (state_q == S_IDLE);
  assign full          = (count_q == CW'(cwp_pkg::MAX_POINTS));
  assign ram_we        = cmd_xfer && (cmd_if.opcode == cwp_pkg::OP_APPEND) && !full;
  assign ram_re        = (state_q == S_RD);
  assign out_free      = !out_valid_q || pos_if.ready;

  // neighbors of the current segment, wrapping at the fill count
  assign last_idx = AW'(count_q - CW'(1));
  assign i0 = (seg_q == '0) ? last_idx : seg_q - AW'(1);
  assign i2 = ((CW'(seg_q) + CW'(1)) == count_q) ? '0 : seg_q + AW'(1);
  assign i3 = ((CW'(i2) + CW'(1)) == count_q) ? '0 : i2 + AW'(1);

  cwp_ram #(
    .WIDTH (cwp_pkg::PT_W),
    .DEPTH (cwp_pkg::MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({cmd_if.point_z, cmd_if.point_y, cmd_if.point_x}),
    .re_i    (ram_re),
    .raddr_i (idx_q[rd_slot_q]),
    .rdata_o (ram_rdata)
  );

  // coordinate k of the four control points, sign extended
  always_comb begin
    logic [CRD_W-1:0] w0, w1, w2, w3;
    w0 = pt_q[0][k_q*CRD_W +: CRD_W];
    w1 = pt_q[1][k_q*CRD_W +: CRD_W];
    w2 = pt_q[2][k_q*CRD_W +: CRD_W];
    w3 = pt_q[3][k_q*CRD_W +: CRD_W];
    p0 = {{(ACC_W-CRD_W){w0[CRD_W-1]}}, w0};
    p1 = {{(ACC_W-CRD_W){w1[CRD_W-1]}}, w1};
    p2 = {{(ACC_W-CRD_W){w2[CRD_W-1]}}, w2};
    p3 = {{(ACC_W-CRD_W){w3[CRD_W-1]}}, w3};
  end

  assign coef_a = p1 << 1;
  assign coef_b = p2 - p0;
  assign coef_c = (p0 << 1) - (p1 << 2) - p1 + (p2 << 2) - p3;
  assign coef_d = (p1 << 1) + p1 - p0 - (p2 << 1) - p2 + p3;

  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.mul_a  = acc_q;
    mac_ctrl.mul_b  = {1'b0, frac_q};
    case (step_q)
      2'd0:    mac_ctrl.addend = coef_c_q;
      2'd1:    mac_ctrl.addend = coef_b_q;
      default: mac_ctrl.addend = coef_a_q;
    endcase
    case (state_q)
      S_INC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.mul_a  = ACC_W'(speed_q);
        mac_ctrl.mul_b  = {1'b0, ft_q};
      end
      S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
      end
      default: begin
        mac_ctrl.mul_en = 1'b0;
      end
    endcase
  end

  cwp_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .prod_o (mac_prod),
    .sum_o  (mac_sum)
  );

  assign inc      = mac_prod[cwp_pkg::INC_SH +: INC_W];
  assign frac_sum = SUM_W'(frac_q) + SUM_W'(inc);

  assign half_acc = $signed(acc_q) >>> 1;
  assign sat_hi   = half_acc > $signed(cwp_pkg::ACC_POS_MAX);
  assign sat_lo   = half_acc < $signed(cwp_pkg::ACC_NEG_MIN);
  assign sat_val  = sat_hi ? cwp_pkg::ACC_POS_MAX[CRD_W-1:0] :
                    sat_lo ? cwp_pkg::ACC_NEG_MIN[CRD_W-1:0] :
                             half_acc[CRD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= cwp_pkg::SPEED_RESET;
    end else if (cfg_we_i) begin
      speed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      seg_q       <= '0;
      frac_q      <= '0;
      rd_slot_q   <= '0;
      cap_q       <= 1'b0;
      k_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q <= ram_re;
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pos_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (ram_we) begin
            count_q <= count_q + CW'(1);
          end
          if (cmd_xfer && (cmd_if.opcode == cwp_pkg::OP_TICK) && (count_q != '0)) begin
            rd_slot_q <= '0;
            state_q   <= S_RD;
          end
        end
        S_RD: begin
          rd_slot_q <= rd_slot_q + 2'd1;
          if (rd_slot_q == 2'd3) begin
            state_q <= S_RDW;
          end
        end
        S_RDW:  state_q <= S_INC;
        S_INC:  state_q <= S_INC2;
        S_INC2: begin
          k_q     <= '0;
          state_q <= S_COEF;
        end
        S_COEF: begin
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_ADD;
        S_ADD: begin
          if (step_q == 2'd2) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          if (k_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_COEF;
          end
        end
        S_OUT: begin
          // hold until the output register is free, then commit the path state
          if (out_free) begin
            frac_q  <= wrap_q ? '0 : nfrac_q;
            seg_q   <= wrap_q ? idx_q[2] : idx_q[1];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cap_slot_q <= rd_slot_q;
    if (cap_q) begin
      pt_q[cap_slot_q] <= ram_rdata;
    end
    if (cmd_xfer) begin
      idx_q[0] <= i0;
      idx_q[1] <= seg_q;
      idx_q[2] <= i2;
      idx_q[3] <= i3;
      ft_q     <= cmd_if.frame_time;
      clip_q   <= 1'b0;
    end
    if (state_q == S_INC2) begin
      wrap_q  <= |frac_sum[SUM_W-1:T_W];
      nfrac_q <= frac_sum[T_W-1:0];
    end
    if (state_q == S_COEF) begin
      coef_a_q <= coef_a;
      coef_b_q <= coef_b;
      coef_c_q <= coef_c;
      acc_q    <= coef_d;
    end
    if (state_q == S_ADD) begin
      acc_q <= mac_sum;
    end
    if (state_q == S_FIN) begin
      pos_q[k_q] <= sat_val;
      clip_q     <= clip_q | sat_hi | sat_lo;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_x_q    <= pos_q[0];
      out_y_q    <= pos_q[1];
      out_z_q    <= pos_q[2];
      out_clip_q <= clip_q;
    end
  end

  assign pos_if.valid   = out_valid_q;
  assign pos_if.pos_x   = out_x_q;
  assign pos_if.pos_y   = out_y_q;
  assign pos_if.pos_z   = out_z_q;
  assign pos_if.clipped = out_clip_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(cwp_pkg::MAX_POINTS))
    else $error("waypoint count beyond ring size");

  a_seg_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(seg_q) < count_q))
    else $error("segment index outside the filled ring");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_xfer && (cmd_if.opcode == cwp_pkg::OP_TICK) && (count_q != '0))
      |=> (state_q == S_RD))
    else $error("tick with waypoints did not start evaluation");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result presented outside the output step");

endmodule

[dv/tb_catmull_rom_waypoint_path_unit.sv]
// Testbench for the Catmull-Rom waypoint path unit: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_catmull_rom_waypoint_path_unit;
  import cwp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYC   = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 105;

  localparam logic [COORD_W-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COORD_W-1:0] C_ONES = 32'hFFFF_FFFF;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MIN = -64'sd2147483648;

  localparam logic [PHASES-1:0][SPEED_W-1:0] PH_SPEED = {
    16'h0180, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0040, 16'h0100, 16'h0080
  };

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [T_W-1:0]     ft;
  } wp_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               clipped;
  } path_pos_t;

  typedef struct packed {
    logic               set_speed;
    logic [SPEED_W-1:0] speed;
    wp_cmd_t            cmd;
    logic               typed;
    path_pos_t          want;
  } tab_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [SPEED_W-1:0] cfg_wdata_i = SPEED_RESET;

  cwp_cmd_if cmd_bus ();
  cwp_pos_if pos_bus ();

  catmull_rom_waypoint_path_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_if      (cmd_bus),
    .pos_if      (pos_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Path model state
  longint             ring_pt [MAX_POINTS][3];
  int                 ring_count = 0;
  int                 seg_idx    = 0;
  int                 seg_frac   = 0;
  logic [SPEED_W-1:0] speed_q88  = SPEED_RESET;

  path_pos_t pos_expected [$];
  path_pos_t pos_head;
  tab_row_t  dir_tab [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt    = 0;
  bit        src_idle_en  = 1'b1;
  bit        snk_idle_en  = 1'b1;

  function automatic longint spline_axis(longint p0, longint p1, longint p2, longint p3,
                                         longint t);
    longint a, b, c, d, acc;
    a   = 2 * p1;
    b   = p2 - p0;
    c   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d   = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = d;
    acc = ((acc * t) >>> 16) + c;
    acc = ((acc * t) >>> 16) + b;
    acc = ((acc * t) >>> 16) + a;
    return acc >>> 1;
  endfunction

  // Apply one command to the path model; return 1 when it yields a position.
  function automatic bit path_step(input wp_cmd_t c, output path_pos_t p);
    int                 idx;
    int                 sel [4];
    longint             v, inc, sum;
    logic               clip;
    logic [COORD_W-1:0] res [3];
    p    = '0;
    clip = 1'b0;
    if (c.opcode == OP_APPEND) begin
      if (ring_count < MAX_POINTS) begin
        ring_pt[ring_count][0] = longint'($signed(c.x));
        ring_pt[ring_count][1] = longint'($signed(c.y));
        ring_pt[ring_count][2] = longint'($signed(c.z));
        ring_count++;
      end
      return 1'b0;
    end
    if (ring_count == 0) return 1'b0;
    idx    = seg_idx % ring_count;
    sel[0] = (idx + ring_count - 1) % ring_count;
    sel[1] = idx;
    sel[2] = (idx + 1) % ring_count;
    sel[3] = (idx + 2) % ring_count;
    for (int k = 0; k < 3; k++) begin
      v = spline_axis(ring_pt[sel[0]][k], ring_pt[sel[1]][k], ring_pt[sel[2]][k],
                      ring_pt[sel[3]][k], longint'(seg_frac));
      if (v > POS_MAX) begin
        v    = POS_MAX;
        clip = 1'b1;
      end else if (v < NEG_MIN) begin
        v    = NEG_MIN;
        clip = 1'b1;
      end
      res[k] = v[COORD_W-1:0];
    end
    p.x       = res[0];
    p.y       = res[1];
    p.z       = res[2];
    p.clipped = clip;
    inc = (longint'(speed_q88) * longint'(c.ft)) >> INC_SH;
    sum = longint'(seg_frac) + inc;
    // any overflow of the fraction moves exactly one segment on
    if (sum >= 65536) begin
      seg_frac = 0;
      seg_idx  = (idx + 1) % ring_count;
    end else begin
      seg_frac = int'(sum);
      seg_idx  = idx;
    end
    return 1'b1;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      3:       return C_MAX;
      4:       return C_MIN;
      default: return $urandom_range(0, 1) ? C_ONES : '0;
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_ft();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(1, 16'h07FF);
      default: return $urandom;
    endcase
  endfunction

  function automatic void tab_cmd(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z, logic [T_W-1:0] ft,
                                  logic typed, path_pos_t want);
    tab_row_t r;
    r           = '0;
    r.cmd       = '{opcode: op, x: x, y: y, z: z, ft: ft};
    r.typed     = typed;
    r.want      = want;
    dir_tab     = {dir_tab, r};
  endfunction

  function automatic void tab_speed(logic [SPEED_W-1:0] v);
    tab_row_t r;
    r           = '0;
    r.set_speed = 1'b1;
    r.speed     = v;
    dir_tab     = {dir_tab, r};
  endfunction

  // Present one command, hold it until the transfer, then record its expected position.
  task automatic send_cmd(input wp_cmd_t c, input logic typed, input path_pos_t want);
    int        gap;
    path_pos_t p;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.opcode     <= c.opcode;
    cmd_bus.point_x    <= c.x;
    cmd_bus.point_y    <= c.y;
    cmd_bus.point_z    <= c.z;
    cmd_bus.frame_time <= c.ft;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (path_step(c, p)) begin
      if (typed) p = want;
      pos_expected = {pos_expected, p};
    end
  endtask

  task automatic drain_and_settle();
    cmd_bus.valid <= 1'b0;
    while (pos_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] v);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    speed_q88 = v;
  endtask

  // Position sink: random back-pressure bursts
  initial begin : sink_ready
    int burst;
    burst         = 0;
    pos_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        pos_bus.ready <= 1'b0;
        burst--;
      end else if (snk_idle_en && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        pos_bus.ready <= 1'b0;
      end else begin
        pos_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pos_bus.valid && pos_bus.ready) begin
      if (pos_expected.size() == 0) begin
        $error("unexpected position transfer: x %h y %h z %h clipped %b",
               pos_bus.pos_x, pos_bus.pos_y, pos_bus.pos_z, pos_bus.clipped);
        mismatch_cnt++;
      end else begin
        pos_head = pos_expected.pop_front();
        if (pos_bus.pos_x !== pos_head.x) begin
          $error("pos_x: expected %h, got %h", pos_head.x, pos_bus.pos_x);
          mismatch_cnt++;
        end
        if (pos_bus.pos_y !== pos_head.y) begin
          $error("pos_y: expected %h, got %h", pos_head.y, pos_bus.pos_y);
          mismatch_cnt++;
        end
        if (pos_bus.pos_z !== pos_head.z) begin
          $error("pos_z: expected %h, got %h", pos_head.z, pos_bus.pos_z);
          mismatch_cnt++;
        end
        if (pos_bus.clipped !== pos_head.clipped) begin
          $error("clipped: expected %b, got %b", pos_head.clipped, pos_bus.clipped);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wp_cmd_t c;
    int      counted;
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = OP_APPEND;
    cmd_bus.point_x    = '0;
    cmd_bus.point_y    = '0;
    cmd_bus.point_z    = '0;
    cmd_bus.frame_time = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring: tick gives nothing
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_APPEND, C_MAX, C_MIN, '0, 16'hFFFF, 1'b0, '0);
    // one point: every fraction lands on the point itself
    tab_cmd(OP_TICK, C_ONES, C_ONES, C_ONES, 16'h0000, 1'b1, {C_MAX, C_MIN, 32'h0, 1'b0});
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b1, {C_MAX, C_MIN, 32'h0, 1'b0});
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b1, {C_MAX, C_MIN, 32'h0, 1'b0});
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b1, {C_MAX, C_MIN, 32'h0, 1'b0});
    tab_cmd(OP_APPEND, C_MIN, C_MAX, C_ONES, 16'h0000, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h0000, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h1234, 1'b0, '0);
    // full-scale swings overshoot and saturate
    tab_cmd(OP_APPEND, C_MAX, C_MAX, C_MIN, 16'h0000, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h8000, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h4000, 1'b0, '0);
    tab_cmd(OP_APPEND, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 16'h0000, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h7FFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    // huge increment still advances one segment only
    tab_speed(16'hFFFF);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h0001, 1'b0, '0);
    tab_speed(16'h0000);
    tab_cmd(OP_TICK, '0, '0, '0, 16'hFFFF, 1'b0, '0);
    tab_cmd(OP_TICK, '0, '0, '0, 16'h5555, 1'b0, '0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_speed) write_speed(dir_tab[i].speed);
      else send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_speed((ph == 5 || ph == 6) ? SPEED_W'($urandom) : PH_SPEED[ph]);
      if (ph == PHASES - 1) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        c.opcode = OP_TICK;
        c.x      = rand_coord();
        c.y      = rand_coord();
        c.z      = rand_coord();
        c.ft     = rand_ft();
        if (ring_count < MAX_POINTS) begin
          if ($urandom_range(0, 11) == 0) c.opcode = OP_APPEND;
        end else if ($urandom_range(0, 24) == 0) begin
          c.opcode = OP_APPEND;
        end
        // appends to a full ring are dropped by the block; do not count them
        if (!(c.opcode == OP_APPEND && ring_count == MAX_POINTS)) counted++;
        send_cmd(c, 1'b0, '0);
      end
    end

    drain_and_settle();
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
